FILE: design/tdar_pkg.sv
// Package for the time-of-day adder and rounder.
// Holds operation and unit codes, field limits, the sequencer state type and
// the divider result struct. No dependencies.
`default_nettype none

package tdar_pkg;

  localparam int NumFields = 6;

  typedef logic [2:0] idx_t;

  // Operation codes carried in tuser
  typedef enum logic [2:0] {
    MODE_ADD   = 3'd0,
    MODE_ROUND = 3'd1,
    MODE_CEIL  = 3'd2,
    MODE_FLOOR = 3'd3,
    MODE_LOAD  = 3'd4
  } mode_t;

  // Field indices, lowest radix first
  localparam idx_t UNIT_NS   = 3'd0;
  localparam idx_t UNIT_US   = 3'd1;
  localparam idx_t UNIT_MS   = 3'd2;
  localparam idx_t UNIT_SEC  = 3'd3;
  localparam idx_t UNIT_MIN  = 3'd4;
  localparam idx_t UNIT_HOUR = 3'd5;

  localparam logic [4:0] HOUR_MAX = 5'd23;
  localparam logic [5:0] MIN_MAX  = 6'd59;
  localparam logic [5:0] SEC_MAX  = 6'd59;
  localparam logic [9:0] SUB_MAX  = 10'd999;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TEST,
    S_STEP,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic [9:0]  rem;
  } div_res_t;

  // Radix of each field
  function automatic logic [9:0] radix(input idx_t i);
    logic [9:0] r;
    unique case (i)
      UNIT_NS, UNIT_US, UNIT_MS: r = 10'd1000;
      UNIT_SEC, UNIT_MIN:        r = 10'd60;
      default:                   r = 10'd24;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/tdar_div.sv
// Iterative unsigned divider by a field radix, eight quotient bits a cycle.
// 32-bit dividend, 10-bit divisor; busy while dividing, then a one-cycle done.
// Depends on tdar_pkg.
`default_nettype none

module tdar_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [31:0]        dividend,
  input  wire logic [9:0]         divisor,
  output tdar_pkg::div_res_t      res
);
  import tdar_pkg::*;

  logic        busy;
  logic [1:0]  cnt;
  logic [31:0] quot;
  logic [9:0]  rem;
  logic [9:0]  dvs;
  logic        done;
  logic [31:0] quot_next;
  logic [9:0]  rem_next;

  // eight restoring steps on an 11-bit partial remainder
  always_comb begin
    logic [10:0] part;
    logic [31:0] q;
    logic [9:0]  r;
    q = quot;
    r = rem;
    for (int i = 0; i < 8; i++) begin
      part = {r, q[31]};
      q    = {q[30:0], 1'b0};
      if (part >= {1'b0, dvs}) begin
        part = part - {1'b0, dvs};
        q[0] = 1'b1;
      end
      r = part[9:0];
    end
    quot_next = q;
    rem_next  = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      quot <= quot_next;
      rem  <= rem_next;
    end
  end

  assign res = '{done: done, quot: quot, rem: rem};

endmodule

`default_nettype wire

FILE: design/time_of_day_adder_rounder.sv
// Time-of-day adder and rounder: top level with field registers, sequencer
// and result register. Depends on tdar_pkg and tdar_div.
//
// Channel  Dir  Bits                  Content
// s_axis   in   tuser 6, tdata 80     one command beat: mode, unit, amount, load value
// m_axis   out  tdata 80              time after the command and its day carry
//
// Sequence: load, floor, unused modes and rounding to ns go straight to the
// result register. An add or a rounding bump walks up the fields one at a time;
// a field whose sum stays inside its radix is written directly, one that carries
// goes through the shared radix divider. An add stops at a field that fits or
// after the hour field. Round/ceiling to unit u tests each field below u, with a
// bump ripple after each one that rounds up. The divider (8 quotient bits a
// cycle) is shared by all fields.
// Reset: synchronous, clears time to 00:00:00.000000000 and drops m_axis_tvalid.
// Stalls: s_axis_tready is high only between commands; a result waiting on
// m_axis_tready lets the next command be taken and worked, then holds it in S_DONE.
`default_nettype none

module time_of_day_adder_rounder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tuser: mode[2:0], unit[5:3]
  input  wire logic [5:0]  s_axis_tuser,
  // tdata: amount[31:0], load_hour[36:32], load_minute[42:37],
  //        load_second[48:43], load_millisecond[58:49],
  //        load_microsecond[68:59], load_nanosecond[78:69], zero [79]
  input  wire logic [79:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: out_hour[4:0], out_minute[10:5], out_second[16:11],
  //        out_millisecond[26:17], out_microsecond[36:27],
  //        out_nanosecond[46:37], day_carry[74:47], zero [79:75]
  output logic [79:0]      m_axis_tdata
);
  import tdar_pkg::*;

  // ---- time fields ----
  logic [4:0] f_hour;
  logic [5:0] f_min;
  logic [5:0] f_sec;
  logic [9:0] f_ms;
  logic [9:0] f_us;
  logic [9:0] f_ns;

  // ---- command context ----
  state_t             state, state_next;
  mode_t              op;
  idx_t               unit_q;
  idx_t               k;          // field being rounded
  idx_t               j;          // field being carried into
  logic signed [33:0] cin;        // carry into field j
  logic signed [27:0] carry;      // day carry of this command
  logic               neg;        // sign of the sum handed to the divider

  // ---- accept-side decode ----
  logic       accept;
  mode_t      in_mode;
  idx_t       in_unit;
  idx_t       unit_c;
  logic [31:0] in_amount;
  logic [4:0] ld_hour;
  logic [5:0] ld_min;
  logic [5:0] ld_sec;
  logic [9:0] ld_ms;
  logic [9:0] ld_us;
  logic [9:0] ld_ns;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign in_mode   = mode_t'(s_axis_tuser[2:0]);
  assign in_unit   = s_axis_tuser[5:3];
  assign unit_c    = (in_unit > UNIT_HOUR) ? UNIT_HOUR : in_unit;  // 6, 7 act as hour
  assign in_amount = s_axis_tdata[31:0];

  // load values saturate at each field's maximum
  assign ld_hour = (s_axis_tdata[36:32] > HOUR_MAX) ? HOUR_MAX : s_axis_tdata[36:32];
  assign ld_min  = (s_axis_tdata[42:37] > MIN_MAX)  ? MIN_MAX  : s_axis_tdata[42:37];
  assign ld_sec  = (s_axis_tdata[48:43] > SEC_MAX)  ? SEC_MAX  : s_axis_tdata[48:43];
  assign ld_ms   = (s_axis_tdata[58:49] > SUB_MAX)  ? SUB_MAX  : s_axis_tdata[58:49];
  assign ld_us   = (s_axis_tdata[68:59] > SUB_MAX)  ? SUB_MAX  : s_axis_tdata[68:59];
  assign ld_ns   = (s_axis_tdata[78:69] > SUB_MAX)  ? SUB_MAX  : s_axis_tdata[78:69];

  // ---- single field read port ----
  idx_t       sel;
  logic [9:0] rd_val;

  assign sel = (state == S_TEST) ? k : j;

  always_comb begin
    unique case (sel)
      UNIT_NS:   rd_val = f_ns;
      UNIT_US:   rd_val = f_us;
      UNIT_MS:   rd_val = f_ms;
      UNIT_SEC:  rd_val = {4'd0, f_sec};
      UNIT_MIN:  rd_val = {4'd0, f_min};
      UNIT_HOUR: rd_val = {5'd0, f_hour};
      default:   rd_val = '0;
    endcase
  end

  // ---- round test ----
  logic [9:0] rad_k;
  logic       up;

  assign rad_k = radix(k);
  assign up    = (op == MODE_ROUND) ? (rd_val >= {1'b0, rad_k[9:1]}) : (rd_val != 10'd0);

  // ---- carry step into field j ----
  logic [9:0]         rad_j;
  logic signed [33:0] vsum;
  logic [33:0]        vmag;
  logic               fits;

  assign rad_j = radix(j);
  assign vsum  = $signed({24'd0, rd_val}) + cin;
  assign vmag  = vsum[33] ? (34'd0 - vsum) : vsum;
  assign fits  = !vsum[33] && (vsum < $signed({24'd0, rad_j}));

  // ---- shared radix divider ----
  logic     div_start;
  div_res_t div_res;

  tdar_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (vmag[31:0]),
    .divisor  (rad_j),
    .res      (div_res)
  );

  // floor correction of the magnitude quotient
  logic [9:0]         fld;
  logic signed [33:0] cout;

  always_comb begin
    if (!neg) begin
      fld  = div_res.rem;
      cout = $signed({2'd0, div_res.quot});
    end else if (div_res.rem == 10'd0) begin
      fld  = '0;
      cout = -$signed({2'd0, div_res.quot});
    end else begin
      fld  = rad_j - div_res.rem;
      cout = -($signed({2'd0, div_res.quot}) + 34'sd1);
    end
  end

  // end of one carry chain
  logic chain_end;
  logic last_k;

  assign last_k    = ((k + idx_t'(1)) == unit_q);
  assign chain_end = ((state == S_STEP) && fits) ||
                     ((state == S_DIV) && div_res.done && (j == UNIT_HOUR));

  // ---- next state ----
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority case (in_mode)
            MODE_ADD:               state_next = S_STEP;
            MODE_ROUND, MODE_CEIL:  state_next = (unit_c == UNIT_NS) ? S_DONE : S_TEST;
            default:                state_next = S_DONE;
          endcase
        end
      end
      S_TEST: begin
        if (up)          state_next = S_STEP;
        else if (last_k) state_next = S_DONE;
      end
      S_STEP: begin
        if (!fits) state_next = S_DIV;
      end
      S_DIV: begin
        if (div_res.done && (j != UNIT_HOUR)) state_next = S_STEP;
      end
      S_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    if (chain_end) state_next = ((op == MODE_ADD) || last_k) ? S_DONE : S_TEST;
  end

  // ---- sequencer outputs ----
  logic       wr_en;
  idx_t       wr_idx;
  logic [9:0] wr_val;
  logic       out_load;

  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    wr_en         = 1'b0;
    wr_idx        = j;
    wr_val        = '0;
    out_load      = 1'b0;
    unique case (state)
      S_IDLE: s_axis_tready = 1'b1;
      S_TEST: begin
        wr_en  = 1'b1;       // field k is cleared whether it rounds up or not
        wr_idx = k;
      end
      S_STEP: begin
        wr_en     = fits;
        wr_val    = vsum[9:0];
        div_start = !fits;
      end
      S_DIV: begin
        wr_en  = div_res.done;
        wr_val = fld;
      end
      S_DONE: out_load = !m_axis_tvalid || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---- field registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      f_hour <= '0;
      f_min  <= '0;
      f_sec  <= '0;
      f_ms   <= '0;
      f_us   <= '0;
      f_ns   <= '0;
    end else if (accept && (in_mode == MODE_LOAD)) begin
      f_hour <= ld_hour;
      f_min  <= ld_min;
      f_sec  <= ld_sec;
      f_ms   <= ld_ms;
      f_us   <= ld_us;
      f_ns   <= ld_ns;
    end else if (accept && (in_mode == MODE_FLOOR)) begin
      if (unit_c > UNIT_NS)  f_ns  <= '0;
      if (unit_c > UNIT_US)  f_us  <= '0;
      if (unit_c > UNIT_MS)  f_ms  <= '0;
      if (unit_c > UNIT_SEC) f_sec <= '0;
      if (unit_c > UNIT_MIN) f_min <= '0;
    end else if (wr_en) begin
      unique case (wr_idx)
        UNIT_NS:   f_ns   <= wr_val;
        UNIT_US:   f_us   <= wr_val;
        UNIT_MS:   f_ms   <= wr_val;
        UNIT_SEC:  f_sec  <= wr_val[5:0];
        UNIT_MIN:  f_min  <= wr_val[5:0];
        UNIT_HOUR: f_hour <= wr_val[4:0];
        default: ;
      endcase
    end
  end

  // ---- command context ----
  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= in_mode;
      unit_q <= unit_c;
      k      <= UNIT_NS;
      j      <= unit_c;
      cin    <= {{2{in_amount[31]}}, in_amount};
      carry  <= '0;
    end else begin
      if ((state == S_TEST) && up) begin
        j   <= k + idx_t'(1);
        cin <= 34'sd1;
      end
      if (((state == S_TEST) && !up) || chain_end) k <= k + idx_t'(1);
      if (div_start) neg <= vsum[33];
      if ((state == S_DIV) && div_res.done) begin
        if (j == UNIT_HOUR) begin
          carry <= carry + cout[27:0];
        end else begin
          j   <= j + idx_t'(1);
          cin <= cout;
        end
      end
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {5'd0, carry, f_ns, f_us, f_ms, f_sec, f_min, f_hour};
    end
  end

  // ---- assertions ----
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_axis_tready)
    else $error("command taken while previous one in progress");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> (state == S_DIV))
    else $error("divider finished outside divide state");

  a_test_below_unit: assert property (@(posedge clk) disable iff (rst)
    (state == S_TEST) |-> (k < unit_q))
    else $error("round test beyond target unit");

  a_fields_in_range: assert property (@(posedge clk) disable iff (rst)
    (f_hour <= HOUR_MAX) && (f_min <= MIN_MAX) && (f_sec <= SEC_MAX) &&
    (f_ms <= SUB_MAX) && (f_us <= SUB_MAX) && (f_ns <= SUB_MAX))
    else $error("time field out of range");

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking bench for time_of_day_adder_rounder: a directed table, then
// random commands, checked beat by beat against a behavioural clock model or a
// hand-written result. Depends on tdar_pkg and the design files only.
`default_nettype none

module tb;
  import tdar_pkg::*;

  localparam int     RAND_ITEMS       = 1500;
  localparam int     MAX_IDLE         = 18;    // longest gap / stall per beat
  localparam int     IDLE_LIMIT       = 2000;  // cycles with no beat on either side
  localparam int     DRAIN_CYCLES     = 64;    // margin above the longest add
  localparam int     SHOWN_MISMATCHES = 10;
  localparam longint DAY_NS           = 64'd86400000000000;

  // Codes with no operation behind them
  localparam logic [2:0] MODE_SPARE = 3'd5;  // 5 to 7 leave the time alone
  localparam logic [2:0] UNIT_WIDE  = 3'd6;  // 6 and 7 behave as hour

  typedef struct packed {
    logic [2:0]         mode;
    logic [2:0]         unit;
    logic signed [31:0] amount;
    logic [4:0]         ld_hour;
    logic [5:0]         ld_min;
    logic [5:0]         ld_sec;
    logic [9:0]         ld_ms;
    logic [9:0]         ld_us;
    logic [9:0]         ld_ns;
  } cmd_t;

  typedef struct packed {
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic [9:0]         milli;
    logic [9:0]         micro;
    logic [9:0]         nano;
    logic signed [27:0] carry;
  } tod_res_t;

  // One line of the directed table; want is only used when has_want is set
  typedef struct packed {
    cmd_t     cmd;
    logic     has_want;
    tod_res_t want;
  } plan_row_t;

  logic        clk;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [5:0]  s_axis_tuser  = '0;
  logic [79:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;

  time_of_day_adder_rounder i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),   // mode[2:0], unit[5:3]
    .s_axis_tdata  (s_axis_tdata),   // amount, hour, min, sec, ms, us, ns, pad
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // hour, min, sec, ms, us, ns, day carry, pad
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Clock model: tod_field[0] is ns ... tod_field[5] is hour
  // ---------------------------------------------------------------------------
  longint    tod_field [0:5];
  tod_res_t  expected_times [$];
  plan_row_t plan_q [$];

  int n_sent     = 0;
  int n_directed = 0;
  int n_checked  = 0;
  int n_mismatch = 0;
  int n_adds     = 0;
  int n_rounds   = 0;
  int n_loads    = 0;
  int n_spare    = 0;

  function automatic longint field_radix(int k);
    case (k)
      UNIT_SEC, UNIT_MIN: return 60;
      UNIT_HOUR:          return 24;
      default:            return 1000;
    endcase
  endfunction

  // nanoseconds in one step of unit u
  function automatic longint unit_span(int u);
    longint s;
    s = 1;
    for (int k = 0; k < u; k++) s = s * field_radix(k);
    return s;
  endfunction

  function automatic longint clock_ns();
    longint t;
    t = 0;
    for (int k = NumFields - 1; k >= 0; k--) t = t * field_radix(k) + tod_field[k];
    return t;
  endfunction

  function automatic void set_clock(longint t);
    for (int k = 0; k < NumFields; k++) begin
      tod_field[k] = t % field_radix(k);
      t = t / field_radix(k);
    end
  endfunction

  // +1 at field k, rippling upwards; 1 when it wraps past midnight
  function automatic longint ripple_up(int k);
    while (k < NumFields) begin
      tod_field[k]++;
      if (tod_field[k] < field_radix(k)) return 0;
      tod_field[k] = 0;
      k++;
    end
    return 1;
  endfunction

  // Applies one command to the model and returns the beat it should produce
  function automatic tod_res_t step_clock(cmd_t c);
    tod_res_t r;
    longint   scale, low, per_day, tot, q, amt, carry;
    int       u;
    logic     up;
    u     = (c.unit > UNIT_HOUR) ? int'(UNIT_HOUR) : int'(c.unit);
    amt   = c.amount;
    carry = 0;
    case (c.mode)
      MODE_ADD: begin
        // fields at and above the add unit move; the finer fields stay put
        n_adds++;
        scale   = unit_span(u);
        low     = clock_ns() % scale;
        per_day = DAY_NS / scale;
        tot     = clock_ns() / scale + amt;
        q       = tot / per_day;
        if (tot % per_day < 0) q--;
        set_clock((tot - q * per_day) * scale + low);
        carry = q;
      end
      MODE_ROUND, MODE_CEIL: begin
        // cascades: each field is folded into the next before that one is tested
        n_rounds++;
        for (int k = 0; k < u; k++) begin
          up = (c.mode == MODE_ROUND) ? (tod_field[k] >= field_radix(k) / 2)
                                      : (tod_field[k] > 0);
          if (up) carry += ripple_up(k + 1);
          tod_field[k] = 0;
        end
      end
      MODE_FLOOR: begin
        n_rounds++;
        for (int k = 0; k < u; k++) tod_field[k] = 0;
      end
      MODE_LOAD: begin
        // out-of-range fields clamp to their maximum
        n_loads++;
        tod_field[UNIT_HOUR] = (c.ld_hour > HOUR_MAX) ? HOUR_MAX : c.ld_hour;
        tod_field[UNIT_MIN]  = (c.ld_min  > MIN_MAX)  ? MIN_MAX  : c.ld_min;
        tod_field[UNIT_SEC]  = (c.ld_sec  > SEC_MAX)  ? SEC_MAX  : c.ld_sec;
        tod_field[UNIT_MS]   = (c.ld_ms   > SUB_MAX)  ? SUB_MAX  : c.ld_ms;
        tod_field[UNIT_US]   = (c.ld_us   > SUB_MAX)  ? SUB_MAX  : c.ld_us;
        tod_field[UNIT_NS]   = (c.ld_ns   > SUB_MAX)  ? SUB_MAX  : c.ld_ns;
      end
      default: n_spare++;
    endcase
    r.hour   = 5'(tod_field[UNIT_HOUR]);
    r.minute = 6'(tod_field[UNIT_MIN]);
    r.second = 6'(tod_field[UNIT_SEC]);
    r.milli  = 10'(tod_field[UNIT_MS]);
    r.micro  = 10'(tod_field[UNIT_US]);
    r.nano   = 10'(tod_field[UNIT_NS]);
    r.carry  = 28'(carry);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Command builders
  // ---------------------------------------------------------------------------
  function automatic cmd_t mk_op(logic [2:0] mode, logic [2:0] unit,
                                 logic signed [31:0] amount);
    cmd_t c;
    c        = '0;
    c.mode   = mode;
    c.unit   = unit;
    c.amount = amount;
    return c;
  endfunction

  function automatic cmd_t mk_load(logic [4:0] h, logic [5:0] m, logic [5:0] s,
                                   logic [9:0] ms, logic [9:0] us, logic [9:0] ns);
    cmd_t c;
    c         = mk_op(MODE_LOAD, UNIT_NS, 0);
    c.ld_hour = h;
    c.ld_min  = m;
    c.ld_sec  = s;
    c.ld_ms   = ms;
    c.ld_us   = us;
    c.ld_ns   = ns;
    return c;
  endfunction

  function automatic tod_res_t mk_time(logic [4:0] h, logic [5:0] m, logic [5:0] s,
                                       logic [9:0] ms, logic [9:0] us, logic [9:0] ns,
                                       logic signed [27:0] carry);
    tod_res_t r;
    r.hour   = h;
    r.minute = m;
    r.second = s;
    r.milli  = ms;
    r.micro  = us;
    r.nano   = ns;
    r.carry  = carry;
    return r;
  endfunction

  task automatic plan(cmd_t c, logic has_want, tod_res_t want);
    plan_row_t row;
    row.cmd      = c;
    row.has_want = has_want;
    row.want     = want;
    plan_q       = {plan_q, row};
  endtask

  // ---------------------------------------------------------------------------
  // Random commands: weighted towards field edges and rounding thresholds
  // ---------------------------------------------------------------------------
  function automatic logic [9:0] rand_sub();
    case ($urandom_range(0, 4))
      0:       return 10'($urandom_range(0, 1023));     // full width, clamps
      1:       return SUB_MAX - 10'($urandom_range(0, 2));
      2:       return 10'($urandom_range(499, 501));    // half-up threshold
      default: return 10'($urandom_range(0, 999));
    endcase
  endfunction

  function automatic logic [5:0] rand_sixty();
    case ($urandom_range(0, 4))
      0:       return 6'($urandom_range(0, 63));
      1:       return MIN_MAX;
      2:       return 6'($urandom_range(29, 30));
      default: return 6'($urandom_range(0, 59));
    endcase
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int   pick;
    c    = '0;
    pick = $urandom_range(0, 99);
    if (pick < 40)      c.mode = MODE_ADD;
    else if (pick < 52) c.mode = MODE_ROUND;
    else if (pick < 64) c.mode = MODE_CEIL;
    else if (pick < 74) c.mode = MODE_FLOOR;
    else if (pick < 93) c.mode = MODE_LOAD;
    else                c.mode = MODE_SPARE + 3'($urandom_range(0, 2));
    if ($urandom_range(0, 6) == 0) c.unit = UNIT_WIDE + 3'($urandom_range(0, 1));
    else                           c.unit = 3'($urandom_range(UNIT_NS, UNIT_HOUR));
    case ($urandom_range(0, 9))
      0:       c.amount = 32'sh7fffffff;
      1:       c.amount = 32'sh80000000;
      2, 3:    c.amount = 32'($urandom);
      4, 5:    c.amount = 32'(int'($urandom_range(0, 65535)) - 32768);
      default: c.amount = 32'(int'($urandom_range(0, 6)) - 3);
    endcase
    // load fields are filled for every mode; only a load may look at them
    case ($urandom_range(0, 3))
      0:       c.ld_hour = 5'($urandom_range(0, 31));
      1:       c.ld_hour = HOUR_MAX;
      default: c.ld_hour = 5'($urandom_range(0, HOUR_MAX));
    endcase
    c.ld_min = rand_sixty();
    c.ld_sec = rand_sixty();
    c.ld_ms  = rand_sub();
    c.ld_us  = rand_sub();
    c.ld_ns  = rand_sub();
    return c;
  endfunction

  // Presents one command after gap idle cycles and holds it until taken.
  // tvalid is only written once per edge, so back-to-back beats stay high.
  task automatic send(cmd_t c, int gap);
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {c.unit, c.mode};
    s_axis_tdata  <= {1'b0, c.ld_ns, c.ld_us, c.ld_ms, c.ld_sec, c.ld_min,
                      c.ld_hour, c.amount};
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    n_sent++;
  endtask

  function automatic string fmt_time(tod_res_t r);
    return $sformatf("%0d:%02d:%02d.%03d%03d%03d carry %0d",
                     r.hour, r.minute, r.second, r.milli, r.micro, r.nano, r.carry);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int       gap;
    cmd_t     c;
    tod_res_t pred;

    for (int k = 0; k < NumFields; k++) tod_field[k] = 0;

    // Directed table: hand-written results only where they are obvious
    plan(mk_op(MODE_FLOOR, UNIT_HOUR, 0), 1'b1, mk_time(0, 0, 0, 0, 0, 0, 0));
    plan(mk_op(MODE_ADD, UNIT_NS, -1), 1'b1, mk_time(23, 59, 59, 999, 999, 999, -1));
    plan(mk_op(MODE_ADD, UNIT_NS, 1), 1'b1, mk_time(0, 0, 0, 0, 0, 0, 1));
    plan(mk_load(31, 63, 63, 1023, 1023, 1023), 1'b1,
         mk_time(23, 59, 59, 999, 999, 999, 0));
    // unit 7 rounds as hour; rounding the last ns of the day wraps
    plan(mk_op(MODE_ROUND, UNIT_WIDE + 3'd1, 0), 1'b1, mk_time(0, 0, 0, 0, 0, 0, 1));
    plan(mk_op(MODE_ADD, UNIT_HOUR, 24), 1'b1, mk_time(0, 0, 0, 0, 0, 0, 1));
    plan(mk_load(12, 30, 30, 500, 500, 500), 1'b1, mk_time(12, 30, 30, 500, 500, 500, 0));
    plan(mk_op(MODE_ROUND, UNIT_MS, 0), 1'b0, '0);
    plan(mk_op(MODE_CEIL, UNIT_NS, 0), 1'b0, '0);      // no-op unit
    plan(mk_op(MODE_CEIL, UNIT_MIN, 0), 1'b0, '0);
    plan(mk_op(MODE_FLOOR, UNIT_SEC, 0), 1'b0, '0);
    plan(mk_op(MODE_SPARE, UNIT_HOUR, 5), 1'b0, '0);
    plan(mk_op(MODE_SPARE + 3'd2, UNIT_NS, -7), 1'b0, '0);
    plan(mk_op(MODE_ADD, UNIT_HOUR, 32'sh7fffffff), 1'b0, '0);
    plan(mk_op(MODE_ADD, UNIT_HOUR, 32'sh80000000), 1'b0, '0);
    plan(mk_op(MODE_ADD, UNIT_NS, 32'sh7fffffff), 1'b0, '0);
    plan(mk_op(MODE_ADD, UNIT_US, 32'sh80000000), 1'b0, '0);
    plan(mk_op(MODE_ADD, UNIT_MS, 32'sh7fffffff), 1'b0, '0);
    plan(mk_op(MODE_ADD, UNIT_SEC, 32'sh80000000), 1'b0, '0);
    plan(mk_op(MODE_ADD, UNIT_MIN, 32'sh7fffffff), 1'b0, '0);
    plan(mk_op(MODE_ADD, UNIT_WIDE, 5), 1'b0, '0);
    // half a second before midnight: rounding to seconds ripples into the day
    plan(mk_load(23, 59, 59, 500, 0, 0), 1'b1, mk_time(23, 59, 59, 500, 0, 0, 0));
    plan(mk_op(MODE_ROUND, UNIT_SEC, 0), 1'b0, '0);
    plan(mk_load(0, 0, 0, 0, 0, 0), 1'b1, mk_time(0, 0, 0, 0, 0, 0, 0));
    plan(mk_op(MODE_CEIL, UNIT_HOUR, 0), 1'b0, '0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan_q[i]) begin
      gap = $urandom_range(0, MAX_IDLE);
      send(plan_q[i].cmd, gap);
      pred = step_clock(plan_q[i].cmd);
      if (plan_q[i].has_want) pred = plan_q[i].want;
      expected_times = {expected_times, pred};
    end
    n_directed = n_sent;

    // Random part; every fourth run of 100 commands goes back to back
    for (int i = 0; i < RAND_ITEMS; i++) begin
      c   = rand_cmd();
      gap = ((i / 100) % 4 == 3) ? 0 : $urandom_range(0, MAX_IDLE);
      send(c, gap);
      pred           = step_clock(c);
      expected_times = {expected_times, pred};
    end
    s_axis_tvalid <= 1'b0;

    while (expected_times.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);  // anything extra shows up here

    $display("tb: %0d commands (%0d directed): %0d adds, %0d roundings, %0d loads, %0d unused",
             n_sent, n_directed, n_adds, n_rounds, n_loads, n_spare);
    $display("tb: %0d result beats checked, %0d mismatches", n_checked, n_mismatch);
    if (n_mismatch == 0 && expected_times.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and beat-by-beat comparison
  // ---------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin : check_results
    tod_res_t got, want;
    int       pause;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      got.hour   = m_axis_tdata[4:0];
      got.minute = m_axis_tdata[10:5];
      got.second = m_axis_tdata[16:11];
      got.milli  = m_axis_tdata[26:17];
      got.micro  = m_axis_tdata[36:27];
      got.nano   = m_axis_tdata[46:37];
      got.carry  = m_axis_tdata[74:47];
      n_checked++;
      if (expected_times.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= SHOWN_MISMATCHES)
          $display("tb: beat %0d arrived with nothing pending: %s", n_checked, fmt_time(got));
      end else begin
        want = expected_times.pop_front();
        if (got.hour != want.hour || got.minute != want.minute ||
            got.second != want.second || got.milli != want.milli ||
            got.micro != want.micro || got.nano != want.nano ||
            got.carry != want.carry) begin
          n_mismatch++;
          if (n_mismatch <= SHOWN_MISMATCHES)
            $display("tb: beat %0d expected %s, got %s",
                     n_checked, fmt_time(want), fmt_time(got));
        end
      end
      // stretches of zero stall now and then
      pause         = ((n_checked / 90) % 4 == 2) ? 0 : $urandom_range(0, MAX_IDLE);
      stall_left    <= pause;
      m_axis_tready <= (pause == 0);
    end else if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= (stall_left == 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without a beat on either side means a hang
  // ---------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: no beat for %0d cycles, %0d results still pending",
               IDLE_LIMIT, expected_times.size());
      $display("tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

`default_nettype wire
